// ----- rtl/dts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants of the delimited token scanner
// Token dictionary, delimiter codes, queue item type and parameter defaults.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int NUM_TOKENS_DEF         = 11;
  localparam int MAX_TOKEN_LEN_DEF      = 16;
  localparam int ITEM_QUEUE_DEPTH_DEF   = 2;
  localparam int RESULT_QUEUE_DEPTH_DEF = 2;

  localparam int DICT_SIZE = 11;
  localparam int DICT_COLS = 16;
  localparam int COL_W     = $clog2(DICT_COLS);
  localparam int LEN_W     = 5;

  localparam logic [7:0] CHAR_COLON   = 8'h3a;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  localparam logic [LEN_W-1:0] DICT_LEN [DICT_SIZE] = '{
    5'd3, 5'd8, 5'd6, 5'd11, 5'd12, 5'd12, 5'd7, 5'd10, 5'd11, 5'd7, 5'd13
  };

  // token bytes, zero padded
  localparam logic [7:0] DICT_TEXT [DICT_SIZE][DICT_COLS] = '{
    '{8'h6b, 8'h73, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6b, 8'h73, 8'h75, 8'h5f, 8'h66, 8'h69, 8'h6c, 8'h65,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6d, 8'h61, 8'h67, 8'h69, 8'h73, 8'h6b, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6d, 8'h61, 8'h67, 8'h69, 8'h73, 8'h6b, 8'h5f, 8'h66,
      8'h69, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6c, 8'h73, 8'h70, 8'h6f, 8'h73, 8'h65, 8'h64, 8'h5f,
      8'h66, 8'h69, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h64, 8'h72, 8'h6f, 8'h69, 8'h64, 8'h73, 8'h70, 8'h61,
      8'h63, 8'h65, 8'h73, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6d, 8'h73, 8'h64, 8'h5f, 8'h61, 8'h70, 8'h70, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6d, 8'h73, 8'h64, 8'h5f, 8'h64, 8'h61, 8'h65, 8'h6d,
      8'h6f, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h78, 8'h70, 8'h6f, 8'h73, 8'h65, 8'h64, 8'h5f, 8'h64,
      8'h61, 8'h74, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h61, 8'h64, 8'h62, 8'h72, 8'h6f, 8'h6f, 8'h74, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h61, 8'h64, 8'h62, 8'h5f, 8'h64, 8'h61, 8'h74, 8'h61,
      8'h5f, 8'h66, 8'h69, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00}
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_colon;
    logic       is_delim;
  } dts_item_t;

endpackage
`default_nettype wire

// ----- rtl/dts_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dts_fifo: small register queue
// Push/full on the write side, pop/empty on the read side, head shown directly.
// ----------------------------------------------------------------------------
module dts_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] data_o,
  output      logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("queue count missed a push");
`endif

endmodule
`default_nettype wire

// ----- rtl/dts_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dts_front: input classification
// Takes each byte, flags colon and delimiter, and hands the item to the queue.
// ----------------------------------------------------------------------------
module dts_front (
  input  wire logic               push_i,
  input  wire logic               queue_full_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               last_byte_i,
  output      logic               queue_push_o,
  output      dts_pkg::dts_item_t item_o
);

  import dts_pkg::*;

  assign queue_push_o     = push_i && !queue_full_i;
  assign item_o.data_byte = data_byte_i;
  assign item_o.last_byte = last_byte_i;
  assign item_o.is_colon  = (data_byte_i == CHAR_COLON);
  assign item_o.is_delim  = (data_byte_i == CHAR_COLON) || (data_byte_i == CHAR_SPACE) ||
                            (data_byte_i == CHAR_NUL) || (data_byte_i == CHAR_NEWLINE);

endmodule
`default_nettype wire

// ----- rtl/dts_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dts_back: token matcher
// Tracks the window after each colon, compares all tokens in parallel and
// emits the sticky found flag on the last byte of a string.
// ----------------------------------------------------------------------------
module dts_back #(
  parameter int NUM_TOKENS    = dts_pkg::NUM_TOKENS_DEF,
  parameter int MAX_TOKEN_LEN = dts_pkg::MAX_TOKEN_LEN_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  input  wire dts_pkg::dts_item_t item_i,
  output      logic               item_pop_o,
  input  wire logic               res_full_i,
  output      logic               res_push_o,
  output      logic               res_found_o
);

  import dts_pkg::*;

  localparam int PosW = $clog2(MAX_TOKEN_LEN + 1);

  logic                  colon_seen_q, colon_seen_d;
  logic [PosW-1:0]       pos_q, pos_d, pos_inc;
  logic [NUM_TOKENS-1:0] alive_q, alive_d;
  logic                  found_q, found_d;
  logic [NUM_TOKENS-1:0] tok_next, tok_done, tok_done_after;
  logic [LEN_W-1:0]      pos_ext, pos_d_ext;
  logic                  pos_open, step, found_fin;

  assign pos_ext   = LEN_W'(pos_q);
  assign pos_d_ext = LEN_W'(pos_d);
  assign pos_open  = (pos_q < PosW'(MAX_TOKEN_LEN));
  assign pos_inc   = pos_open ? pos_q + PosW'(1) : pos_q;

  for (genvar gi = 0; gi < NUM_TOKENS; gi++) begin : g_tok
    if (gi < DICT_SIZE) begin : g_used
      logic [7:0] tok_char;
      assign tok_char = (pos_ext < LEN_W'(DICT_COLS)) ?
                        DICT_TEXT[gi][pos_ext[COL_W-1:0]] : 8'h00;
      assign tok_next[gi] = alive_q[gi] && (DICT_LEN[gi] > pos_ext) && pos_open &&
                            (tok_char == item_i.data_byte);
      assign tok_done[gi]       = alive_q[gi] && (DICT_LEN[gi] == pos_ext);
      assign tok_done_after[gi] = alive_d[gi] && (DICT_LEN[gi] == pos_d_ext);
    end else begin : g_unused
      assign tok_next[gi]       = 1'b0;
      assign tok_done[gi]       = 1'b0;
      assign tok_done_after[gi] = 1'b0;
    end
  end

  assign step        = item_valid_i && !(item_i.last_byte && res_full_i);
  assign item_pop_o  = step;
  assign res_push_o  = step && item_i.last_byte;
  assign found_fin   = found_d || (colon_seen_d && (|tok_done_after));
  assign res_found_o = found_fin;

  always_comb begin
    colon_seen_d = colon_seen_q;
    pos_d        = pos_q;
    alive_d      = alive_q;
    found_d      = found_q;
    if (step) begin
      if (colon_seen_q) begin
        if (item_i.is_delim && (|tok_done)) begin
          found_d = 1'b1;
        end
        alive_d = tok_next;
        pos_d   = pos_inc;
      end
      if (item_i.is_colon) begin
        colon_seen_d = 1'b1;
        pos_d        = '0;
        alive_d      = '1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colon_seen_q <= 1'b0;
      pos_q        <= '0;
      alive_q      <= '0;
      found_q      <= 1'b0;
    end else if (res_push_o) begin
      colon_seen_q <= 1'b0;
      pos_q        <= '0;
      alive_q      <= '0;
      found_q      <= 1'b0;
    end else begin
      colon_seen_q <= colon_seen_d;
      pos_q        <= pos_d;
      alive_q      <= alive_d;
      found_q      <= found_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (!colon_seen_q && !found_q && (alive_q == '0) && (pos_q == '0)))
    else $error("scan state not cleared after string end");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= PosW'(MAX_TOKEN_LEN))
    else $error("window position past saturation");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !colon_seen_q |-> ((alive_q == '0) && (pos_q == '0) && !found_q))
    else $error("window state without an open colon");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && !step) |-> (item_i.last_byte && res_full_i))
    else $error("matcher stalled without a full result queue");
`endif

endmodule
`default_nettype wire

// ----- rtl/delimited_token_scanner_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// delimited_token_scanner_top: colon-prefixed token scanner
// Scans a byte string for dictionary tokens opened by a colon and closed by
// a delimiter or the end of the string.
// ----------------------------------------------------------------------------
// usage:
//   input channel: push, full; one byte per item with data_byte_i and
//   last_byte_i, taken at an edge with push high and full low
//   result channel: empty, pop; found_o is valid while empty is low and is
//   taken at an edge with pop high and empty low
//   one result per string, produced by the item that has last_byte_i set
//   throughput: one item per cycle unless the matcher stalls, set by the
//   single matching step of the matcher; all tokens are compared in
//   parallel each cycle; the last byte is registered in the item queue
//   and its result is registered in the result queue, driving found_o
//   reset: both queues empty and the scan state clear; full is low at once
//   stall: results wait in the result queue; once it is full the matcher
//   holds the next last byte, the item queue fills and full rises
//   an empty string cannot be sent
// ----------------------------------------------------------------------------
module delimited_token_scanner_top #(
  parameter int NUM_TOKENS         = dts_pkg::NUM_TOKENS_DEF,
  parameter int MAX_TOKEN_LEN      = dts_pkg::MAX_TOKEN_LEN_DEF,
  parameter int ITEM_QUEUE_DEPTH   = dts_pkg::ITEM_QUEUE_DEPTH_DEF,
  parameter int RESULT_QUEUE_DEPTH = dts_pkg::RESULT_QUEUE_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output      logic       full,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output      logic       empty,
  input  wire logic       pop,
  output      logic       found_o
);

  import dts_pkg::*;

  dts_item_t front_item, back_item;
  logic      front_push, item_full, item_empty, item_pop;
  logic      res_push, res_found, res_full;

  dts_front u_front (
    .push_i       (push),
    .queue_full_i (item_full),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .queue_push_o (front_push),
    .item_o       (front_item)
  );

  dts_fifo #(
    .WIDTH ($bits(dts_item_t)),
    .DEPTH (ITEM_QUEUE_DEPTH)
  ) u_item_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_item),
    .full_o  (item_full),
    .pop_i   (item_pop),
    .data_o  (back_item),
    .empty_o (item_empty)
  );

  dts_back #(
    .NUM_TOKENS    (NUM_TOKENS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!item_empty),
    .item_i       (back_item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_found_o  (res_found)
  );

  dts_fifo #(
    .WIDTH (1),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_found),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (found_o),
    .empty_o (empty)
  );

  assign full = item_full;

endmodule
`default_nettype wire
